@@ rtl/core/itchp_pkg.sv @@
package itchp_pkg;

    localparam int MAX_MESSAGE_BYTES = 64;
    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);
    localparam int NUM_TYPES = 22;
    localparam int MAX_FIELDS = 15;
    localparam int SLOTS = 4;
    localparam int SLOT_W = 2;
    localparam int FIDX_W = 4;
    localparam int TIDX_W = 5;
    localparam int RAM_DEPTH = SLOTS * 16;
    localparam int RAM_AW = SLOT_W + FIDX_W;

    typedef logic [2:0] fkind_t;
    localparam fkind_t K_NUM   = 3'd0;
    localparam fkind_t K_YN    = 3'd1;
    localparam fkind_t K_SIDE  = 3'd2;
    localparam fkind_t K_PRINT = 3'd3;
    localparam fkind_t K_TEXT  = 3'd4;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_UNSUP     = 3'd1;
    localparam status_t ST_BAD_LEN   = 3'd2;
    localparam status_t ST_BAD_YN    = 3'd3;
    localparam status_t ST_BAD_SIDE  = 3'd4;
    localparam status_t ST_BAD_PRINT = 3'd5;

    localparam logic [7:0] CH_Y = 8'h59;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        fkind_t     kind;
        logic [5:0] off;
        logic [3:0] len;
    } fdesc_t;

    typedef struct packed {
        logic [7:0] kind;
        logic [3:0] nf;
        status_t    status;
    } desc_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [3:0]  idx;
        logic [63:0] value;
        status_t     status;
        logic        last;
    } out_t;

    typedef struct packed {
        logic              hit;
        logic [FIDX_W-1:0] idx;
        fkind_t            kind;
        logic              first;
        logic              done;
    } fhit_t;

    typedef struct packed {
        logic              ok;
        logic [TIDX_W-1:0] idx;
    } thit_t;

    function automatic fdesc_t mk(fkind_t k, int o, int l);
        fdesc_t d;
        d.kind = k;
        d.off = 6'(o);
        d.len = 4'(l);
        return d;
    endfunction

    function automatic fdesc_t ft();
        return mk(K_NUM, 5, 6);
    endfunction
    function automatic fdesc_t fn(int o, int l);
        return mk(K_NUM, o, l);
    endfunction
    function automatic fdesc_t fc(int o);
        return mk(K_NUM, o, 1);
    endfunction
    function automatic fdesc_t fy(int o);
        return mk(K_YN, o, 1);
    endfunction
    function automatic fdesc_t fd(int o);
        return mk(K_SIDE, o, 1);
    endfunction
    function automatic fdesc_t fp(int o);
        return mk(K_PRINT, o, 1);
    endfunction
    function automatic fdesc_t fx(int o, int l);
        return mk(K_TEXT, o, l);
    endfunction
    function automatic fdesc_t fs(int o);
        return mk(K_TEXT, o, 8);
    endfunction

    localparam fdesc_t FNONE = '{kind: K_NUM, off: 6'd0, len: 4'd0};

    typedef fdesc_t row_t [MAX_FIELDS];

    localparam row_t LAYOUT [NUM_TYPES] = '{
        '{0: ft(), 1: fc(11), default: FNONE},
        '{0: ft(), 1: fs(11), 2: fc(19), 3: fc(20), 4: fn(21, 4), 5: fy(25), 6: fc(26),
          7: fx(27, 2), 8: fc(29), 9: fc(30), 10: fc(31), 11: fc(32), 12: fc(33),
          13: fn(34, 4), 14: fy(38)},
        '{0: ft(), 1: fs(11), 2: fc(19), 3: fx(21, 4), default: FNONE},
        '{0: ft(), 1: fs(11), 2: fc(19), default: FNONE},
        '{0: ft(), 1: fx(11, 4), 2: fs(15), 3: fy(23), 4: fc(24), 5: fc(25),
          default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fn(19, 8), 3: fn(27, 8), default: FNONE},
        '{0: ft(), 1: fc(11), default: FNONE},
        '{0: ft(), 1: fs(11), 2: fn(19, 4), 3: fc(23), 4: fn(24, 4), default: FNONE},
        '{0: ft(), 1: fs(11), 2: fn(19, 4), 3: fn(27, 4), 4: fn(23, 4), 5: fn(31, 4),
          default: FNONE},
        '{0: ft(), 1: fs(11), 2: fc(19), 3: fc(20), default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fd(19), 3: fn(20, 4), 4: fs(24), 5: fn(32, 4),
          default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fd(19), 3: fn(20, 4), 4: fs(24), 5: fn(32, 4),
          6: fx(36, 4), default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fn(19, 4), 3: fn(23, 8), default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fn(19, 4), 3: fn(23, 8), 4: fp(31), 5: fn(32, 4),
          default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fn(19, 4), default: FNONE},
        '{0: ft(), 1: fn(11, 8), default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fn(19, 8), 3: fn(27, 4), 4: fn(31, 4),
          default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fd(19), 3: fn(20, 4), 4: fs(24), 5: fn(32, 4),
          6: fn(36, 8), default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fs(19), 3: fn(27, 4), 4: fn(31, 8), 5: fc(39),
          default: FNONE},
        '{0: ft(), 1: fn(11, 8), default: FNONE},
        '{0: ft(), 1: fn(11, 8), 2: fn(19, 8), 3: fc(27), 4: fs(28), 5: fn(36, 4),
          6: fn(40, 4), 7: fn(44, 4), 8: fc(48), 9: fc(49), default: FNONE},
        '{0: ft(), 1: fs(11), 2: fc(19), default: FNONE}
    };

    localparam logic [7:0] TYPE_CHAR [NUM_TYPES] = '{
        8'h53, 8'h52, 8'h48, 8'h59, 8'h4C, 8'h56, 8'h57, 8'h4B, 8'h4A, 8'h68, 8'h41,
        8'h46, 8'h45, 8'h43, 8'h58, 8'h44, 8'h55, 8'h50, 8'h51, 8'h42, 8'h49, 8'h4E
    };

    localparam logic [5:0] MSG_LEN [NUM_TYPES] = '{
        6'd12, 6'd39, 6'd25, 6'd20, 6'd26, 6'd35, 6'd12, 6'd28, 6'd35, 6'd21, 6'd36,
        6'd40, 6'd31, 6'd36, 6'd23, 6'd19, 6'd35, 6'd44, 6'd40, 6'd19, 6'd50, 6'd20
    };

    localparam logic [3:0] NUM_FIELDS [NUM_TYPES] = '{
        4'd2, 4'd15, 4'd4, 4'd3, 4'd6, 4'd4, 4'd2, 4'd5, 4'd6, 4'd4, 4'd6,
        4'd7, 4'd4, 4'd6, 4'd3, 4'd2, 4'd5, 4'd7, 4'd6, 4'd2, 4'd10, 4'd3
    };

    function automatic thit_t type_lookup(logic [7:0] b);
        thit_t r;
        r.ok = 1'b0;
        r.idx = '0;
        for (int i = 0; i < NUM_TYPES; i++) begin
            if (b == TYPE_CHAR[i]) begin
                r.ok = 1'b1;
                r.idx = TIDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic fhit_t field_lookup(logic [TIDX_W-1:0] t, logic [CNT_W-1:0] off);
        fhit_t r;
        fdesc_t d;
        int o;
        int s;
        int e;
        r = '0;
        for (int f = 0; f < MAX_FIELDS; f++) begin
            d = (int'(t) < NUM_TYPES) ? LAYOUT[int'(t)][f] : FNONE;
            o = int'(off);
            s = int'(d.off);
            e = s + int'(d.len);
            if (o >= s && o < e) begin
                r.hit = 1'b1;
                r.idx = FIDX_W'(f);
                r.kind = d.kind;
                r.first = (o == s);
                r.done = (o == e - 1);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/itchp_ram.sv @@
module itchp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ rtl/core/itchp_front.sv @@
module itchp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    input  logic                          dq_full,
    input  logic [itchp_pkg::SLOT_W-1:0]  wr_slot,
    output logic                          wr_en,
    output logic [itchp_pkg::RAM_AW-1:0]  wr_addr,
    output logic [63:0]                   wr_data,
    output logic                          push,
    output itchp_pkg::desc_t              push_desc
);

    logic [itchp_pkg::CNT_W-1:0]  cnt_reg, cnt_inc;
    logic                         type_ok_reg, type_ok_cur;
    logic [itchp_pkg::TIDX_W-1:0] tidx_reg, tidx_cur;
    logic [7:0]                   kind_reg, kind_cur;
    logic [63:0]                  acc_reg, acc_next;
    logic [3:0]                   sp_reg, sp_next;
    itchp_pkg::status_t           err_reg, err_next, status;
    itchp_pkg::thit_t             tl;
    itchp_pkg::fhit_t             fh;
    logic                         take, first_byte, hit, is_space;

    assign s_tready = !dq_full;
    assign take = s_tvalid && s_tready;

    always_comb begin
        first_byte = (cnt_reg == '0);
        tl = itchp_pkg::type_lookup(s_tdata);
        type_ok_cur = first_byte ? tl.ok : type_ok_reg;
        tidx_cur = first_byte ? tl.idx : tidx_reg;
        kind_cur = first_byte ? s_tdata : kind_reg;
        fh = itchp_pkg::field_lookup(tidx_reg, cnt_reg);
        hit = fh.hit && !first_byte && type_ok_reg;
        is_space = (s_tdata == itchp_pkg::CH_SPACE);
        acc_next = fh.first ? {56'd0, s_tdata} : {acc_reg[55:0], s_tdata};
        if (fh.first || !is_space) begin
            sp_next = {3'd0, is_space};
        end else begin
            sp_next = sp_reg + 4'd1;
        end
        case (fh.kind)
            itchp_pkg::K_YN, itchp_pkg::K_PRINT: begin
                wr_data = {63'd0, s_tdata == itchp_pkg::CH_Y};
            end
            itchp_pkg::K_TEXT: begin
                wr_data = acc_next & ~((64'd1 << {sp_next, 3'd0}) - 64'd1);
            end
            default: begin
                wr_data = acc_next;
            end
        endcase
        err_next = first_byte ? itchp_pkg::ST_OK : err_reg;
        if (hit && err_next == itchp_pkg::ST_OK) begin
            case (fh.kind)
                itchp_pkg::K_YN: begin
                    if (s_tdata != itchp_pkg::CH_Y && s_tdata != itchp_pkg::CH_N) begin
                        err_next = itchp_pkg::ST_BAD_YN;
                    end
                end
                itchp_pkg::K_PRINT: begin
                    if (s_tdata != itchp_pkg::CH_Y && s_tdata != itchp_pkg::CH_N) begin
                        err_next = itchp_pkg::ST_BAD_PRINT;
                    end
                end
                itchp_pkg::K_SIDE: begin
                    if (s_tdata != itchp_pkg::CH_B && s_tdata != itchp_pkg::CH_S) begin
                        err_next = itchp_pkg::ST_BAD_SIDE;
                    end
                end
                default: begin
                end
            endcase
        end
        if (int'(cnt_reg) <= itchp_pkg::MAX_MESSAGE_BYTES) begin
            cnt_inc = cnt_reg + 1'b1;
        end else begin
            cnt_inc = cnt_reg;
        end
        if (!type_ok_cur) begin
            status = itchp_pkg::ST_UNSUP;
        end else if (cnt_inc != itchp_pkg::CNT_W'(itchp_pkg::MSG_LEN[tidx_cur])) begin
            status = itchp_pkg::ST_BAD_LEN;
        end else begin
            status = err_next;
        end
        wr_en = take && hit && fh.done;
        wr_addr = {wr_slot, fh.idx};
        push = take && s_tlast;
        push_desc.kind = kind_cur;
        push_desc.nf = type_ok_cur ? itchp_pkg::NUM_FIELDS[tidx_cur] : 4'd1;
        push_desc.status = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            type_ok_reg <= 1'b0;
            err_reg <= itchp_pkg::ST_OK;
        end else if (take) begin
            cnt_reg <= s_tlast ? '0 : cnt_inc;
            type_ok_reg <= type_ok_cur;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            tidx_reg <= tidx_cur;
            kind_reg <= kind_cur;
            if (hit) begin
                acc_reg <= acc_next;
                sp_reg <= sp_next;
            end
        end
    end

endmodule

@@ rtl/core/itchp_dq.sv @@
module itchp_dq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  itchp_pkg::desc_t              push_desc,
    input  logic                          pop,
    output itchp_pkg::desc_t              head,
    output logic                          not_empty,
    output logic                          full,
    output logic [itchp_pkg::SLOT_W-1:0]  wr_ptr,
    output logic [itchp_pkg::SLOT_W-1:0]  rd_ptr,
    output logic [itchp_pkg::SLOT_W:0]    count
);

    itchp_pkg::desc_t                q_reg [itchp_pkg::SLOTS];
    logic [itchp_pkg::SLOT_W-1:0]    wr_reg, rd_reg;
    logic [itchp_pkg::SLOT_W:0]      cnt_reg, cnt_next;

    assign wr_ptr = wr_reg;
    assign rd_ptr = rd_reg;
    assign count = cnt_reg;
    assign head = q_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign full = (cnt_reg == (itchp_pkg::SLOT_W+1)'(itchp_pkg::SLOTS));

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= push_desc;
        end
    end

endmodule

@@ rtl/core/itchp_back.sv @@
module itchp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          dq_valid,
    input  itchp_pkg::desc_t              head,
    input  logic [itchp_pkg::SLOT_W-1:0]  rd_slot,
    output logic                          pop,
    output logic [itchp_pkg::RAM_AW-1:0]  rd_addr,
    input  logic [63:0]                   rd_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,
    output logic [7:0]                    m_tuser,
    output logic                          m_tlast
);

    logic [3:0]          idx_reg;
    logic                p1_reg;
    logic                zero_reg;
    itchp_pkg::out_t     pk_reg, pk_in, item;
    itchp_pkg::out_t     q_reg [4];
    logic [1:0]          hd_reg, tl_reg;
    logic [2:0]          ocnt_reg;
    logic                issue, is_err, is_last, opop;

    always_comb begin
        issue = dq_valid && ({1'b0, ocnt_reg} + {3'd0, p1_reg} < 4'd4);
        is_err = (head.status != itchp_pkg::ST_OK);
        is_last = is_err || (idx_reg == head.nf - 4'd1);
        pop = issue && is_last;
        rd_addr = {rd_slot, idx_reg};
        pk_in.kind = head.kind;
        pk_in.idx = is_err ? 4'd0 : idx_reg;
        pk_in.value = '0;
        pk_in.status = head.status;
        pk_in.last = is_last;
        item = pk_reg;
        item.value = zero_reg ? 64'd0 : rd_data;
        m_tvalid = (ocnt_reg != 3'd0);
        opop = m_tvalid && m_tready;
        m_tuser = q_reg[hd_reg].kind;
        m_tdata = {1'b0, q_reg[hd_reg].status, q_reg[hd_reg].value, q_reg[hd_reg].idx};
        m_tlast = q_reg[hd_reg].last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            p1_reg <= 1'b0;
            hd_reg <= '0;
            tl_reg <= '0;
            ocnt_reg <= '0;
        end else begin
            p1_reg <= issue;
            if (issue) begin
                idx_reg <= is_last ? 4'd0 : idx_reg + 4'd1;
            end
            if (p1_reg) begin
                tl_reg <= tl_reg + 2'd1;
            end
            if (opop) begin
                hd_reg <= hd_reg + 2'd1;
            end
            if (p1_reg && !opop) begin
                ocnt_reg <= ocnt_reg + 3'd1;
            end else if (opop && !p1_reg) begin
                ocnt_reg <= ocnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pk_reg <= pk_in;
            zero_reg <= is_err;
        end
        if (p1_reg) begin
            q_reg[tl_reg] <= item;
        end
    end

endmodule

@@ rtl/core/itch_message_field_parser_top.sv @@
// On tlast a descriptor is queued; fields are then read from RAM and output.
// Throughput: one byte item per cycle; one result per cycle while m_tready.
// Input stalls only when four decoded messages wait in the slot queue.
// Field values are built as bytes arrive and kept in a 64-entry field RAM.
// Reset: aresetn synchronous, active low; clears counters and queues.
module itch_message_field_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // field_index, field_value, status, zero pad
    output logic [7:0]  m_tuser,   // message_kind
    output logic        m_tlast
);

    logic                          wr_en, push, pop, dq_full, dq_valid;
    logic [itchp_pkg::RAM_AW-1:0]  wr_addr, rd_addr;
    logic [63:0]                   wr_data, rd_data;
    logic [itchp_pkg::SLOT_W-1:0]  wr_ptr, rd_ptr;
    logic [itchp_pkg::SLOT_W:0]    dq_count;
    itchp_pkg::desc_t              push_desc, head;

    itchp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .dq_full(dq_full), .wr_slot(wr_ptr),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .push(push), .push_desc(push_desc)
    );

    itchp_dq u_dq (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_desc(push_desc), .pop(pop),
        .head(head), .not_empty(dq_valid), .full(dq_full),
        .wr_ptr(wr_ptr), .rd_ptr(rd_ptr), .count(dq_count)
    );

    itchp_ram #(.WIDTH(64), .DEPTH(itchp_pkg::RAM_DEPTH)) u_ram (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
        .raddr(rd_addr), .rdata(rd_data)
    );

    itchp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .dq_valid(dq_valid), .head(head), .rd_slot(rd_ptr), .pop(pop),
        .rd_addr(rd_addr), .rd_data(rd_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    a_dq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dq_count <= (itchp_pkg::SLOT_W+1)'(itchp_pkg::SLOTS))
        else $error("slot queue overflow");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !dq_full)
        else $error("message pushed into full slot queue");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[70:68] != itchp_pkg::ST_OK) |-> m_tlast && (m_tdata[3:0] == 4'd0))
        else $error("status item not a single last item");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> dq_valid)
        else $error("pop from empty slot queue");

endmodule

@@ sim/itch_message_field_parser_checker.sv @@
module itch_message_field_parser_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [7:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [7:0]          kind;
        logic [3:0]          idx;
        logic [63:0]         value;
        itchp_pkg::status_t  status;
        logic                last;
    } field_t;

    typedef struct {
        itchp_pkg::fkind_t kind;
        int                off;
        int                len;
    } layout_field_t;

    field_t        fields_due[$];
    logic [7:0]    msg_bytes[itchp_pkg::MAX_MESSAGE_BYTES];
    int            msg_len;

    function automatic layout_field_t lf(itchp_pkg::fkind_t k, int o, int l);
        layout_field_t r;
        r.kind = k;
        r.off = o;
        r.len = l;
        return r;
    endfunction

    function automatic layout_field_t num(int o, int l);
        return lf(itchp_pkg::K_NUM, o, l);
    endfunction

    function automatic layout_field_t txt(int o, int l);
        return lf(itchp_pkg::K_TEXT, o, l);
    endfunction

    function automatic layout_field_t yn(int o);
        return lf(itchp_pkg::K_YN, o, 1);
    endfunction

    function automatic int layout_of(logic [7:0] t, output layout_field_t f[15]);
        f[0] = num(5, 6);
        case (t)
            "S", "W": begin f[1] = num(11, 1); return 2; end
            "R": begin
                f[1] = txt(11, 8); f[2] = num(19, 1); f[3] = num(20, 1);
                f[4] = num(21, 4); f[5] = yn(25); f[6] = num(26, 1);
                f[7] = txt(27, 2); f[8] = num(29, 1); f[9] = num(30, 1);
                f[10] = num(31, 1); f[11] = num(32, 1);
                f[12] = num(33, 1); f[13] = num(34, 4);
                f[14] = yn(38); return 15;
            end
            "H": begin
                f[1] = txt(11, 8); f[2] = num(19, 1); f[3] = txt(21, 4);
                return 4;
            end
            "Y", "N": begin f[1] = txt(11, 8); f[2] = num(19, 1); return 3; end
            "L": begin
                f[1] = txt(11, 4); f[2] = txt(15, 8); f[3] = yn(23);
                f[4] = num(24, 1); f[5] = num(25, 1); return 6;
            end
            "V": begin
                f[1] = num(11, 8); f[2] = num(19, 8); f[3] = num(27, 8);
                return 4;
            end
            "K": begin
                f[1] = txt(11, 8); f[2] = num(19, 4); f[3] = num(23, 1);
                f[4] = num(24, 4); return 5;
            end
            "J": begin
                f[1] = txt(11, 8); f[2] = num(19, 4); f[3] = num(27, 4);
                f[4] = num(23, 4); f[5] = num(31, 4); return 6;
            end
            "h": begin
                f[1] = txt(11, 8); f[2] = num(19, 1); f[3] = num(20, 1);
                return 4;
            end
            "A", "F", "P": begin
                f[1] = num(11, 8); f[2] = lf(itchp_pkg::K_SIDE, 19, 1); f[3] = num(20, 4);
                f[4] = txt(24, 8); f[5] = num(32, 4);
                if (t == "A") return 6;
                f[6] = (t == "F") ? txt(36, 4) : num(36, 8);
                return 7;
            end
            "E": begin
                f[1] = num(11, 8); f[2] = num(19, 4); f[3] = num(23, 8);
                return 4;
            end
            "C": begin
                f[1] = num(11, 8); f[2] = num(19, 4); f[3] = num(23, 8);
                f[4] = lf(itchp_pkg::K_PRINT, 31, 1); f[5] = num(32, 4); return 6;
            end
            "X": begin f[1] = num(11, 8); f[2] = num(19, 4); return 3; end
            "D", "B": begin f[1] = num(11, 8); return 2; end
            "U": begin
                f[1] = num(11, 8); f[2] = num(19, 8); f[3] = num(27, 4);
                f[4] = num(31, 4); return 5;
            end
            "Q": begin
                f[1] = num(11, 8); f[2] = txt(19, 8); f[3] = num(27, 4);
                f[4] = num(31, 8); f[5] = num(39, 1); return 6;
            end
            "I": begin
                f[1] = num(11, 8); f[2] = num(19, 8); f[3] = num(27, 1);
                f[4] = txt(28, 8); f[5] = num(36, 4); f[6] = num(40, 4);
                f[7] = num(44, 4); f[8] = num(48, 1); f[9] = num(49, 1);
                return 10;
            end
            default: return 0;
        endcase
    endfunction

    function automatic int length_of(logic [7:0] t);
        case (t)
            "S", "W": return 12;
            "R": return 39;
            "H": return 25;
            "Y", "N": return 20;
            "L": return 26;
            "V", "J", "U": return 35;
            "K": return 28;
            "h": return 21;
            "A", "C": return 36;
            "F", "Q": return 40;
            "E": return 31;
            "X": return 23;
            "D", "B": return 19;
            "P": return 44;
            "I": return 50;
            default: return 0;
        endcase
    endfunction

    function automatic logic [63:0] field_value(layout_field_t d);
        logic [7:0]  b[8];
        logic [63:0] v;
        int          n;
        v = '0;
        n = d.len;
        for (int i = 0; i < d.len; i++) b[i] = msg_bytes[d.off + i];
        if (d.kind == itchp_pkg::K_TEXT) begin
            while (n > 0 && b[n-1] == itchp_pkg::CH_SPACE) begin
                b[n-1] = 8'h00;
                n--;
            end
        end
        if (d.kind == itchp_pkg::K_YN || d.kind == itchp_pkg::K_PRINT) begin
            return {63'd0, b[0] == itchp_pkg::CH_Y};
        end
        for (int i = 0; i < d.len; i++) v = {v[55:0], b[i]};
        return v;
    endfunction

    task automatic push_field(logic [7:0] k, int i, logic [63:0] v,
                              itchp_pkg::status_t st, logic l);
        field_t e;
        e.kind = k;
        e.idx = 4'(i);
        e.value = v;
        e.status = st;
        e.last = l;
        fields_due.push_back(e);
    endtask

    task automatic decode_message(int len);
        layout_field_t f[15];
        logic [7:0]    k;
        logic [7:0]    b;
        int            nf;
        k = msg_bytes[0];
        nf = layout_of(k, f);
        if (nf == 0) begin
            push_field(k, 0, '0, itchp_pkg::ST_UNSUP, 1'b1);
            return;
        end
        if (len != length_of(k)) begin
            push_field(k, 0, '0, itchp_pkg::ST_BAD_LEN, 1'b1);
            return;
        end
        for (int i = 0; i < nf; i++) begin
            b = msg_bytes[f[i].off];
            if ((f[i].kind == itchp_pkg::K_YN || f[i].kind == itchp_pkg::K_PRINT)
                && b != itchp_pkg::CH_Y && b != itchp_pkg::CH_N) begin
                push_field(k, 0, '0, (f[i].kind == itchp_pkg::K_YN)
                           ? itchp_pkg::ST_BAD_YN : itchp_pkg::ST_BAD_PRINT, 1'b1);
                return;
            end
            if (f[i].kind == itchp_pkg::K_SIDE && b != itchp_pkg::CH_B
                && b != itchp_pkg::CH_S) begin
                push_field(k, 0, '0, itchp_pkg::ST_BAD_SIDE, 1'b1);
                return;
            end
        end
        for (int i = 0; i < nf; i++) begin
            push_field(k, i, field_value(f[i]), itchp_pkg::ST_OK, i == nf - 1);
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        field_t e;
        if (!aresetn) begin
            msg_len = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (msg_len < itchp_pkg::MAX_MESSAGE_BYTES) msg_bytes[msg_len] = s_tdata;
                if (msg_len <= itchp_pkg::MAX_MESSAGE_BYTES) msg_len++;
                if (s_tlast) begin
                    decode_message(msg_len);
                    msg_len = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (fields_due.size() == 0) begin
                    report("unexpected item", m_tdata[63:0], '0);
                end else begin
                    e = fields_due.pop_front();
                    if (m_tuser != e.kind) begin
                        report("message_kind", 64'(m_tuser), 64'(e.kind));
                    end
                    if (m_tdata[3:0] != e.idx) begin
                        report("field_index", 64'(m_tdata[3:0]), 64'(e.idx));
                    end
                    if (m_tdata[67:4] != e.value) begin
                        report("field_value", m_tdata[67:4], e.value);
                    end
                    if (m_tdata[70:68] != e.status) begin
                        report("status", 64'(m_tdata[70:68]), 64'(e.status));
                    end
                    if (m_tlast != e.last) report("last_field", 64'(m_tlast), 64'(e.last));
                end
            end
        end
        pending = fields_due.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        msg_len = 0;
    end

endmodule

@@ sim/itch_message_field_parser_top_tb.sv @@
module itch_message_field_parser_top_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          burst_left;
    int          stall_mode;
    int          sent_count;

    itch_message_field_parser_top i_dut (.*);

    itch_message_field_parser_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver stall pattern: phases of always-ready, random and sparse
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_byte(logic [7:0] b, logic l);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        sent_count++;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic int msg_length(logic [7:0] t);
        case (t)
            "S", "W": return 12;
            "R": return 39;
            "H": return 25;
            "Y", "N": return 20;
            "L": return 26;
            "V", "J", "U": return 35;
            "K": return 28;
            "h": return 21;
            "A", "C": return 36;
            "F", "Q": return 40;
            "E": return 31;
            "X": return 23;
            "D", "B": return 19;
            "P": return 44;
            "I": return 50;
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte(int mode);
        case (mode)
            0: return 8'($urandom_range(0, 255));
            1: return itchp_pkg::CH_SPACE;
            2: return $urandom_range(0, 1) ? itchp_pkg::CH_Y : itchp_pkg::CH_N;
            default: return $urandom_range(0, 1) ? itchp_pkg::CH_B : itchp_pkg::CH_S;
        endcase
    endfunction

    // flag offsets get legal values unless corrupt is set
    task automatic send_message(logic [7:0] t, int len, bit corrupt, bit trail_spaces);
        logic [7:0] b;
        int         flagmode;
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                b = t;
            end else begin
                flagmode = 0;
                if ((t == "R" && (i == 25 || i == 38)) || (t == "L" && i == 23)
                    || (t == "C" && i == 31)) flagmode = 2;
                if ((t == "A" || t == "F" || t == "P") && i == 19) flagmode = 3;
                if (flagmode != 0 && !corrupt) b = pick_byte(flagmode);
                else if (flagmode != 0) b = 8'($urandom_range(0, 255));
                else if (trail_spaces && $urandom_range(0, 2) == 0) b = pick_byte(1);
                else b = pick_byte(0);
            end
            send_byte(b, i == len - 1);
        end
    endtask

    localparam string KINDS = "SRHYLVWKJhAFECXDUPQBIN";

    initial begin
        logic [7:0] t;
        int         n;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b1;
        stall_mode = 0;
        burst_left = 0;
        sent_count = 0;
        aresetn = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: short, bad-side errors; one good; saturating length
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_message("S", 12, 0, 1);
        send_message("D", 18, 0, 0);
        send_message("A", 36, 1, 0);
        send_message("S", 66, 0, 0);
        s_tvalid <= 1'b0;

        // hold until drained
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        while (sent_count < 300) begin
            n = $urandom_range(0, 19);
            t = KINDS[$urandom_range(0, 21)];
            if (n < 14) send_message(t, msg_length(t), 0, 1);
            else if (n < 16) send_message(t, msg_length(t), 1, 1);
            else if (n < 18) send_message(t, $urandom_range(1, 70), 0, 0);
            else send_message(8'($urandom_range(0, 255)), $urandom_range(1, 60), 1, 1);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/itchp_pkg.sv
rtl/core/itchp_ram.sv
rtl/core/itchp_front.sv
rtl/core/itchp_dq.sv
rtl/core/itchp_back.sv
rtl/core/itch_message_field_parser_top.sv
sim/itch_message_field_parser_checker.sv
sim/itch_message_field_parser_top_tb.sv
